>>> hw/rtl/baro_conversion_sequencer_compensator_macros.svh
// Assertion macros for the baro conversion sequencer compensator checker.
// No dependencies.
`ifndef BARO_CONVERSION_SEQUENCER_COMPENSATOR_MACROS_SVH
`define BARO_CONVERSION_SEQUENCER_COMPENSATOR_MACROS_SVH

// check gated off while reset is high
`define BCSC_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bcsc check failed");

// check that also runs during reset
`define BCSC_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bcsc check failed");

`endif

>>> hw/rtl/bcsc_pkg.sv
// Shared types and constants for the baro conversion sequencer compensator.
// No dependencies.
package bcsc_pkg;

  localparam logic [2:0] REG_C1       = 3'd0;
  localparam logic [2:0] REG_C2       = 3'd1;
  localparam logic [2:0] REG_C3       = 3'd2;
  localparam logic [2:0] REG_C4       = 3'd3;
  localparam logic [2:0] REG_C6       = 3'd4;
  localparam logic [2:0] REG_P_OSR    = 3'd5;
  localparam logic [2:0] REG_T_OSR    = 3'd6;
  localparam logic [2:0] OSR_RESET    = 3'd4;

  localparam logic [7:0] CMD_PRESSURE = 8'h40;
  localparam logic [7:0] CMD_TEMP     = 8'h50;

  // one classified poll, front to back
  typedef struct packed {
    logic        adc_read;
    logic        cmd_valid;
    logic [7:0]  cmd_byte;
    logic        data_ready;
    logic [23:0] raw_pressure;
    logic [31:0] sample_tick;
  } rec_t;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c6;
  } coeff_t;

endpackage

>>> hw/rtl/bcsc_front.sv
// Poll sequencer: conversion timing, command bytes, classification of polls.
// Depends on bcsc_pkg.
module bcsc_front
  import bcsc_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] now_tick,
  input  logic [23:0] adc_word,
  input  logic [2:0]  pressure_osr,
  input  logic [2:0]  temp_osr,
  input  logic        q_full,
  output logic        q_push,
  output rec_t        q_rec
);

  typedef enum logic [1:0] {
    PH_IDLE, PH_WAIT_D1, PH_WAIT_D2
  } phase_t;

  phase_t                 phase;
  logic [TICK_BITS-1:0]   conv_start;
  logic [TICK_BITS-1:0]   inflight;
  logic [23:0]            raw_pressure;
  logic [TICK_BITS-1:0]   now;
  logic [TICK_BITS-1:0]   elapsed;
  logic                   p_due;
  logic                   t_due;

  function automatic logic [4:0] delay_of(input logic [2:0] osr);
    case (osr)
      3'd0:    delay_of = 5'd1;
      3'd1:    delay_of = 5'd2;
      3'd2:    delay_of = 5'd3;
      3'd3:    delay_of = 5'd10;
      default: delay_of = 5'd20;
    endcase
  endfunction

  assign now     = now_tick[TICK_BITS-1:0];
  assign elapsed = now - conv_start;
  assign p_due   = elapsed >= TICK_BITS'(delay_of(pressure_osr));
  assign t_due   = elapsed >= TICK_BITS'(delay_of(temp_osr));
  assign q_push  = push && !q_full;

  always_comb begin
    q_rec = '0;
    q_rec.raw_pressure = raw_pressure;
    q_rec.sample_tick  = 32'(inflight);
    unique case (phase)
      PH_IDLE: begin
        q_rec.cmd_valid = 1'b1;
        q_rec.cmd_byte  = CMD_PRESSURE + {4'd0, pressure_osr, 1'b0};
      end
      PH_WAIT_D1: begin
        if (p_due) begin
          q_rec.adc_read  = 1'b1;
          q_rec.cmd_valid = 1'b1;
          q_rec.cmd_byte  = CMD_TEMP + {4'd0, temp_osr, 1'b0};
        end
      end
      PH_WAIT_D2: begin
        if (t_due) begin
          q_rec.adc_read   = 1'b1;
          q_rec.cmd_valid  = 1'b1;
          q_rec.cmd_byte   = CMD_PRESSURE + {4'd0, pressure_osr, 1'b0};
          q_rec.data_ready = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      conv_start   <= '0;
      inflight     <= '0;
      raw_pressure <= '0;
    end else if (q_push) begin
      unique case (phase)
        PH_IDLE: begin
          inflight   <= now;
          conv_start <= now;
          phase      <= PH_WAIT_D1;
        end
        PH_WAIT_D1: begin
          if (p_due) begin
            raw_pressure <= adc_word;
            conv_start   <= now;
            phase        <= PH_WAIT_D2;
          end
        end
        PH_WAIT_D2: begin
          if (t_due) begin
            inflight   <= now;
            conv_start <= now;
            phase      <= PH_WAIT_D1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/bcsc_queue.sv
// Two-entry queue of classified polls between front and back.
// Depends on bcsc_pkg.
module bcsc_queue
  import bcsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rec_t wr_rec,
  output logic full,
  input  logic rd,
  output logic avail,
  output rec_t rd_rec
);

  rec_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign avail  = count != 2'd0;
  assign rd_rec = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd && avail) rptr <= !rptr;
      count <= count + 2'(wr) - 2'(rd && avail);
    end
  end

endmodule

>>> hw/rtl/bcsc_back.sv
// Compensation engine and result register: divider, shared multiplier, output.
// Depends on bcsc_pkg.
module bcsc_back
  import bcsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  coeff_t             coeff,
  input  logic               q_avail,
  input  rec_t               q_rec,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic               adc_read,
  output logic               cmd_valid,
  output logic [7:0]         cmd_byte,
  output logic               data_ready,
  output logic signed [31:0] pressure,
  output logic [31:0]        sample_tick
);

  localparam logic [31:0] DT_DIVIDEND = 32'd4194304000;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_OUT
  } state_t;

  state_t             state;
  rec_t               cur;
  logic [15:0]        rem;
  logic [31:0]        dsr;
  logic [31:0]        quo;
  logic [4:0]         cnt;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] off;
  logic signed [63:0] sens;
  logic signed [31:0] held_p;
  logic [31:0]        held_tick;
  logic out_valid;

  logic [16:0]        rem_sh;
  logic               ge;
  logic signed [31:0] dt;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic               out_load;

  function automatic logic signed [63:0] tdiv(input logic signed [63:0] x,
                                              input int k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    tdiv = (x + bias) >>> k;
  endfunction

  assign rem_sh = {rem, dsr[31]};
  assign ge     = rem_sh >= {1'b0, coeff.c6};
  assign dt     = (coeff.c6 == 16'd0) ? 32'sd0 : $signed(quo);
  assign q_pop  = (state == S_IDLE) && q_avail;
  assign empty  = !out_valid;
  assign out_load = (state == S_OUT) && (!out_valid || pop);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = $signed({17'd0, coeff.c4});
        mul_b = 33'(dt);
      end
      S_M2: begin
        mul_a = $signed({17'd0, coeff.c3});
        mul_b = 33'(dt);
      end
      S_M4: begin
        mul_a = $signed({9'd0, cur.raw_pressure});
        mul_b = $signed({1'b0, sens[31:0]});
      end
      S_M5: begin
        mul_a = $signed({9'd0, cur.raw_pressure});
        mul_b = $signed({1'b0, sens[63:32]});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held_p    <= '0;
      held_tick <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !pop);
      unique case (state)
        S_IDLE: begin
          if (q_avail) begin
            cur <= q_rec;
            rem <= '0;
            dsr <= DT_DIVIDEND;
            quo <= '0;
            cnt <= '0;
            state <= q_rec.data_ready ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem <= ge ? 16'(rem_sh - {1'b0, coeff.c6}) : rem_sh[15:0];
          quo <= {quo[30:0], ge};
          dsr <= {dsr[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_M1;
        end
        S_M1: begin
          prod  <= mul_p[63:0];
          state <= S_M2;
        end
        S_M2: begin
          off   <= $signed({31'd0, coeff.c2, 17'd0}) + tdiv(prod, 6);
          prod  <= mul_p[63:0];
          state <= S_M3;
        end
        S_M3: begin
          sens  <= $signed({32'd0, coeff.c1, 16'd0}) + tdiv(prod, 7);
          state <= S_M4;
        end
        S_M4: begin
          prod  <= mul_p[63:0];
          state <= S_M5;
        end
        S_M5: begin
          acc   <= prod;
          prod  <= mul_p[63:0];
          state <= S_M6;
        end
        S_M6: begin
          // D1 * SENS modulo 2^64 from the two partial products
          acc   <= acc + {prod[31:0], 32'd0};
          state <= S_M7;
        end
        S_M7: begin
          acc   <= tdiv(acc, 21) - off;
          state <= S_M8;
        end
        S_M8: begin
          held_p    <= 32'(tdiv(acc, 15));
          held_tick <= cur.sample_tick;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            adc_read    <= cur.adc_read;
            cmd_valid   <= cur.cmd_valid;
            cmd_byte    <= cur.cmd_byte;
            data_ready  <= cur.data_ready;
            pressure    <= held_p;
            sample_tick <= held_tick;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/baro_conversion_sequencer_compensator.sv
// Top level: configuration registers, front sequencer, queue, compensation back.
// Depends on bcsc_pkg, bcsc_front, bcsc_queue, bcsc_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  poll in  | push / full        | now_tick, adc_word
//  result   | pop / empty        | adc_read, cmd_valid, cmd_byte, data_ready,
//           |                    | pressure, sample_tick
//  config   | cfg_write          | cfg_index, cfg_data
//
// A poll that computes no pressure goes from the queue entry via the back's
// current record into the result register. One that computes pressure first
// runs the restoring divide of the dT constant by C6, then 8 steps through the
// shared multiplier. The two-entry queue lets polls be taken while the back
// is busy; full rises when it holds two. Reset (synchronous) clears all control state.
module baro_conversion_sequencer_compensator
  import bcsc_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        now_tick,
  input  logic [23:0]        adc_word,
  output logic               empty,
  input  logic               pop,
  output logic               adc_read,
  output logic               cmd_valid,
  output logic [7:0]         cmd_byte,
  output logic               data_ready,
  output logic signed [31:0] pressure,
  output logic [31:0]        sample_tick,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  coeff_t     coeff;
  logic [2:0] pressure_osr;
  logic [2:0] temp_osr;
  logic       q_push;
  rec_t       q_wr_rec;
  logic       q_pop;
  logic       q_avail;
  rec_t       q_rd_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff        <= '0;
      pressure_osr <= OSR_RESET;
      temp_osr     <= OSR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_C1:    coeff.c1     <= cfg_data;
        REG_C2:    coeff.c2     <= cfg_data;
        REG_C3:    coeff.c3     <= cfg_data;
        REG_C4:    coeff.c4     <= cfg_data;
        REG_C6:    coeff.c6     <= cfg_data;
        REG_P_OSR: pressure_osr <= cfg_data[2:0];
        REG_T_OSR: temp_osr     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  bcsc_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk, .rst, .push, .now_tick, .adc_word, .pressure_osr, .temp_osr,
    .q_full(full), .q_push, .q_rec(q_wr_rec)
  );

  bcsc_queue u_queue (
    .clk, .rst, .wr(q_push), .wr_rec(q_wr_rec), .full,
    .rd(q_pop), .avail(q_avail), .rd_rec(q_rd_rec)
  );

  bcsc_back u_back (
    .clk, .rst, .coeff, .q_avail, .q_rec(q_rd_rec), .q_pop,
    .empty, .pop, .adc_read, .cmd_valid, .cmd_byte, .data_ready,
    .pressure, .sample_tick
  );

endmodule

>>> hw/rtl/bcsc_checker.sv
// Port-level checks for the top level, attached by bind.
// Depends on baro_conversion_sequencer_compensator_macros.svh.
`include "baro_conversion_sequencer_compensator_macros.svh"

module bcsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       adc_read,
  input logic       cmd_valid,
  input logic [7:0] cmd_byte,
  input logic       data_ready
);

  `BCSC_CHECK_ALWAYS(a_reset_empty, clk, rst |=> empty)
  `BCSC_CHECK(a_ready_has_read, clk, rst, (!empty && data_ready) |-> (adc_read && cmd_valid))
  `BCSC_CHECK(a_no_cmd_zero, clk, rst, (!empty && !cmd_valid) |-> (cmd_byte == 8'd0))
  `BCSC_CHECK(a_result_holds, clk, rst, (!empty && !pop) |=> !empty)

endmodule

bind baro_conversion_sequencer_compensator bcsc_checker u_bcsc_checker (
  .clk, .rst, .empty, .pop, .adc_read, .cmd_valid, .cmd_byte, .data_ready
);
